// ===== sv/stack_machine_executor_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stack machine executor
// Clocked assertions, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SME_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sme: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SME_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sme: assertion failed");

`endif

// ===== sv/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// sme_pkg
// Shared widths, operation and status codes, and control structs.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int WORD_W      = 32;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_W     = 7;
  localparam int DIV_CNT_W   = $clog2(WORD_W + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_DIV   = 3'd3,
    OP_MUL   = 3'd4,
    OP_PRINT = 3'd5,
    OP_DUP   = 3'd6,
    OP_DUP2  = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic exec;
    logic div_start;
    logic wr2;
    logic div_wr;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller status, valid in the execute cycle
  typedef struct packed {
    logic div_go;
    logic dup2_go;
  } dp_stat_t;

endpackage

// ===== sv/sme_if.sv =====
// ----------------------------------------------------------------------------
// sme_item_if / sme_result_if
// Valid/ready channels for operations in and results out.
// ----------------------------------------------------------------------------
interface sme_item_if;
  logic                              valid;
  logic                              ready;
  logic [sme_pkg::OP_W-1:0]          op;
  logic signed [sme_pkg::WORD_W-1:0] literal;

  modport source (output valid, output op, output literal, input ready);
  modport sink   (input valid, input op, input literal, output ready);
endinterface

interface sme_result_if;
  logic                              valid;
  logic                              ready;
  logic                              printed;
  logic signed [sme_pkg::WORD_W-1:0] print_value;
  logic [sme_pkg::STATUS_W-1:0]      status;
  logic [sme_pkg::DEPTH_W-1:0]       depth;

  modport source (output valid, output printed, output print_value, output status,
                  output depth, input ready);
  modport sink   (input valid, input printed, input print_value, input status,
                  input depth, output ready);
endinterface

// ===== sv/stack_machine_executor.sv =====
// An accepted item is executed (stack read, ALU, write back) and its result
// then emitted; 2dup adds a second write on the single write port, and a
// divide that runs waits for the radix-2 divider. The output can stall, and
// a new item is taken only while idle or while the last result is emitted.
// Reset: synchronous, active high; empties the stack and drops any result.
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one stack operation per beat on a stack of 32-bit signed words.
// ----------------------------------------------------------------------------
module stack_machine_executor (
  input  logic         clk,
  input  logic         rst,
  sme_item_if.sink     item,
  sme_result_if.source result
);

  sme_pkg::dp_cmd_t                 cmd;
  sme_pkg::dp_stat_t                stat;
  logic                             div_done;
  logic [sme_pkg::WORD_W-1:0]       div_num;
  logic [sme_pkg::WORD_W-1:0]       div_den;
  logic [sme_pkg::WORD_W-1:0]       div_quot;
  logic [sme_pkg::WORD_W-1:0]       print_value_u;

  sme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  sme_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (item.op),
    .in_literal  (item.literal),
    .div_num     (div_num),
    .div_den     (div_den),
    .div_quot    (div_quot),
    .printed     (result.printed),
    .print_value (print_value_u),
    .status      (result.status),
    .depth       (result.depth)
  );

  sme_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign result.print_value = print_value_u;

endmodule

// ===== sv/sme_divider.sv =====
// ----------------------------------------------------------------------------
// sme_divider
// Signed truncating divider, restoring radix-2, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sme_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sme_pkg::WORD_W-1:0]  num,
  input  logic [sme_pkg::WORD_W-1:0]  den,
  output logic                        done,
  output logic [sme_pkg::WORD_W-1:0]  quot
);

  logic                             busy;
  logic [sme_pkg::DIV_CNT_W-1:0]    count;
  logic [sme_pkg::WORD_W-1:0]       rem;
  logic [sme_pkg::WORD_W-1:0]       q;
  logic [sme_pkg::WORD_W-1:0]       ud;
  logic                             neg;
  logic [sme_pkg::WORD_W:0]         rem_sh;
  logic [sme_pkg::WORD_W:0]         trial;
  logic                             fits;

  // One restoring step: shift in the next dividend bit, try subtract
  always_comb begin
    rem_sh = {rem, q[sme_pkg::WORD_W-1]};
    trial  = rem_sh - {1'b0, ud};
    fits   = (rem_sh >= {1'b0, ud});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == sme_pkg::DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (count == sme_pkg::DIV_CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  // Load magnitudes on start, then advance one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      q     <= num[sme_pkg::WORD_W-1] ? (~num + 1'b1) : num;
      ud    <= den[sme_pkg::WORD_W-1] ? (~den + 1'b1) : den;
      neg   <= num[sme_pkg::WORD_W-1] ^ den[sme_pkg::WORD_W-1];
      count <= sme_pkg::DIV_CNT_W'(sme_pkg::WORD_W);
    end else if (busy) begin
      rem   <= fits ? trial[sme_pkg::WORD_W-1:0] : rem_sh[sme_pkg::WORD_W-1:0];
      q     <= {q[sme_pkg::WORD_W-2:0], fits};
      count <= count - sme_pkg::DIV_CNT_W'(1);
    end
  end

  // Restore the sign of the quotient
  assign quot = neg ? (~q + 1'b1) : q;

endmodule

// ===== sv/sme_datapath.sv =====
// ----------------------------------------------------------------------------
// sme_datapath
// Stack memory, stack pointer, ALU, error checks and result register.
// ----------------------------------------------------------------------------
module sme_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  sme_pkg::dp_cmd_t                  cmd,
  output sme_pkg::dp_stat_t                 stat,
  input  logic [sme_pkg::OP_W-1:0]          in_op,
  input  logic [sme_pkg::WORD_W-1:0]        in_literal,
  output logic [sme_pkg::WORD_W-1:0]        div_num,
  output logic [sme_pkg::WORD_W-1:0]        div_den,
  input  logic [sme_pkg::WORD_W-1:0]        div_quot,
  output logic                              printed,
  output logic [sme_pkg::WORD_W-1:0]        print_value,
  output logic [sme_pkg::STATUS_W-1:0]      status,
  output logic [sme_pkg::DEPTH_W-1:0]       depth
);

  logic [sme_pkg::WORD_W-1:0] mem [sme_pkg::STACK_DEPTH];

  logic [sme_pkg::SP_W-1:0]     sp;
  logic [sme_pkg::SP_W-1:0]     sp_next;
  sme_pkg::op_t                 op_r;
  logic [sme_pkg::WORD_W-1:0]   lit_r;
  logic [sme_pkg::WORD_W-1:0]   rd_t;
  logic [sme_pkg::WORD_W-1:0]   rd_s;
  logic [sme_pkg::WORD_W-1:0]   hold_t;
  logic                         res_printed;
  logic [sme_pkg::WORD_W-1:0]   res_pval;
  sme_pkg::status_t             res_status;

  logic [sme_pkg::ADDR_W-1:0]   addr_t;
  logic [sme_pkg::ADDR_W-1:0]   addr_s;
  logic [1:0]                   need;
  logic [1:0]                   grow;
  logic                         under;
  logic                         over;
  logic                         divz;
  sme_pkg::status_t             status_c;
  logic                         ok;
  logic [sme_pkg::WORD_W-1:0]   alu;
  logic                         we;
  logic [sme_pkg::ADDR_W-1:0]   waddr;
  logic [sme_pkg::WORD_W-1:0]   wdata;

  assign addr_t = sme_pkg::ADDR_W'(sp - sme_pkg::SP_W'(1));
  assign addr_s = sme_pkg::ADDR_W'(sp - sme_pkg::SP_W'(2));

  // Operand demand and stack growth per operation
  always_comb begin
    unique case (op_r) inside
      sme_pkg::OP_PUSH:  begin need = 2'd0; grow = 2'd1; end
      sme_pkg::OP_PRINT: begin need = 2'd1; grow = 2'd0; end
      sme_pkg::OP_DUP:   begin need = 2'd1; grow = 2'd1; end
      sme_pkg::OP_DUP2:  begin need = 2'd2; grow = 2'd2; end
      default:           begin need = 2'd2; grow = 2'd0; end
    endcase
  end

  // Error checks, underflow first
  always_comb begin
    under = (sp < sme_pkg::SP_W'(need));
    divz  = (op_r == sme_pkg::OP_DIV) && (rd_t == '0);
    over  = ({1'b0, sp} + (sme_pkg::SP_W+1)'(grow)) >
            (sme_pkg::SP_W+1)'(sme_pkg::STACK_DEPTH);
    if (under) begin
      status_c = sme_pkg::ST_UNDER;
    end else if (divz) begin
      status_c = sme_pkg::ST_DIVZ;
    end else if (over) begin
      status_c = sme_pkg::ST_OVER;
    end else begin
      status_c = sme_pkg::ST_OK;
    end
    ok = (status_c == sme_pkg::ST_OK);
  end

  assign stat.div_go  = ok && (op_r == sme_pkg::OP_DIV);
  assign stat.dup2_go = ok && (op_r == sme_pkg::OP_DUP2);

  // Wrapping ALU on top and second
  always_comb begin
    unique case (op_r) inside
      sme_pkg::OP_SUB: alu = rd_t - rd_s;
      sme_pkg::OP_MUL: alu = rd_t * rd_s;
      default:         alu = rd_t + rd_s;
    endcase
  end

  assign div_num = rd_s;
  assign div_den = rd_t;

  // Memory write port and stack pointer update
  always_comb begin
    we      = 1'b0;
    waddr   = sme_pkg::ADDR_W'(sp);
    wdata   = lit_r;
    sp_next = sp;
    if (cmd.exec && ok) begin
      unique case (op_r) inside
        sme_pkg::OP_PUSH: begin
          we      = 1'b1;
          sp_next = sp + sme_pkg::SP_W'(1);
        end
        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL: begin
          we      = 1'b1;
          waddr   = addr_s;
          wdata   = alu;
          sp_next = sp - sme_pkg::SP_W'(1);
        end
        sme_pkg::OP_PRINT: begin
          sp_next = sp - sme_pkg::SP_W'(1);
        end
        sme_pkg::OP_DUP: begin
          we      = 1'b1;
          wdata   = rd_t;
          sp_next = sp + sme_pkg::SP_W'(1);
        end
        sme_pkg::OP_DUP2: begin
          we      = 1'b1;
          wdata   = rd_s;
        end
        default: begin
          we      = 1'b0;
        end
      endcase
    end else if (cmd.wr2) begin
      we      = 1'b1;
      waddr   = sme_pkg::ADDR_W'(sp + sme_pkg::SP_W'(1));
      wdata   = hold_t;
      sp_next = sp + sme_pkg::SP_W'(2);
    end else if (cmd.div_wr) begin
      we      = 1'b1;
      waddr   = addr_s;
      wdata   = div_quot;
      sp_next = sp - sme_pkg::SP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else begin
      sp <= sp_next;
    end
  end

  // Stack memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_t <= mem[addr_t];
    rd_s <= mem[addr_s];
  end

  // Capture the beat, hold operation results, load the result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= sme_pkg::op_t'(in_op);
      lit_r <= in_literal;
    end
    if (cmd.exec) begin
      hold_t      <= rd_t;
      res_status  <= status_c;
      res_printed <= ok && (op_r == sme_pkg::OP_PRINT);
      res_pval    <= (ok && (op_r == sme_pkg::OP_PRINT)) ? rd_t : '0;
    end
    if (cmd.emit) begin
      printed     <= res_printed;
      print_value <= res_pval;
      status      <= res_status;
      depth       <= sme_pkg::DEPTH_W'(sp);
    end
  end

endmodule

// ===== sv/sme_ctrl.sv =====
// ----------------------------------------------------------------------------
// sme_ctrl
// Sequencer for accept, execute, second write, divide wait and result emit.
// ----------------------------------------------------------------------------
`include "stack_machine_executor_assert.svh"

module sme_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  sme_pkg::dp_stat_t  stat,
  input  logic               div_done,
  output sme_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WR2,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  // Result slot is free when empty or draining this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) || ((state == S_EMIT) && out_free);
  assign accept   = in_valid && in_ready;

  // Datapath commands
  always_comb begin
    cmd.accept    = accept;
    cmd.exec      = (state == S_EXEC);
    cmd.div_start = (state == S_EXEC) && stat.div_go;
    cmd.wr2       = (state == S_WR2);
    cmd.div_wr    = (state == S_DIV) && div_done;
    cmd.emit      = (state == S_EMIT) && out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.div_go) begin
          state_next = S_DIV;
        end else if (stat.dup2_go) begin
          state_next = S_WR2;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_WR2: begin
        state_next = S_EMIT;
      end
      S_DIV: begin
        if (div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_next = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SME_ASSERT_NEXT(a_accept_executes, clk, rst, accept, state == S_EXEC)
  `SME_ASSERT_SAME(a_div_done_in_wait, clk, rst, div_done, state == S_DIV)
  `SME_ASSERT_SAME(a_wr2_after_exec, clk, rst, state == S_WR2, $past(state == S_EXEC))

endmodule

// ===== bench/tb_stack_machine_executor.sv =====
// ----------------------------------------------------------------------------
// tb_stack_machine_executor
// Self-checking bench for the stack machine executor. A behavioral stack
// inside the bench predicts printed flag, value, status and depth for every
// accepted operation; each result beat is checked against the oldest
// prediction. Directed edge cases come first, then random programs with
// random gaps on both channels, a fill to a full stack, and a final
// stretch at full rate.
// ----------------------------------------------------------------------------
module tb_stack_machine_executor;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 60;    // covers the iterative divider
  localparam int MAX_PRINTED  = 20;

  typedef struct {
    logic              printed;
    logic [31:0]       value;
    sme_pkg::status_t  status;
    logic [6:0]        depth;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;

  sme_item_if   item_ch ();
  sme_result_if result_ch ();

  stack_machine_executor dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always #2 clk = ~clk;

  // Bench-side copy of the stack
  logic [31:0] model_stack [sme_pkg::STACK_DEPTH];
  int          model_depth = 0;
  outcome_t    awaited_results [$];

  bit idle_on = 1'b1;
  int mismatches = 0;
  int ops_sent = 0;
  int results_seen = 0;
  int prints_seen = 0;
  int status_seen [4];
  int quiet_cycles = 0;
  int ready_hold = 0;

  // Signed division truncated toward zero; min / -1 wraps back to min
  function automatic logic [31:0] trunc_quotient(logic [31:0] num, logic [31:0] den);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] q;
    mag_n = num[31] ? -num : num;
    mag_d = den[31] ? -den : den;
    q = mag_n / mag_d;
    return (num[31] != den[31]) ? -q : q;
  endfunction

  // Apply one operation to the bench stack and queue the outcome it implies
  function automatic void apply_stack_op(sme_pkg::op_t op, logic [31:0] lit);
    int          need;
    int          grow;
    logic [31:0] top;
    logic [31:0] second;
    outcome_t    r;
    top = '0;
    second = '0;
    r.printed = 1'b0;
    r.value = '0;
    r.status = sme_pkg::ST_OK;
    case (op)
      sme_pkg::OP_PUSH:  begin need = 0; grow = 1; end
      sme_pkg::OP_PRINT: begin need = 1; grow = 0; end
      sme_pkg::OP_DUP:   begin need = 1; grow = 1; end
      sme_pkg::OP_DUP2:  begin need = 2; grow = 2; end
      default:           begin need = 2; grow = 0; end
    endcase
    if (model_depth < need) begin
      r.status = sme_pkg::ST_UNDER;
    end else begin
      if (need >= 1) top = model_stack[model_depth-1];
      if (need >= 2) second = model_stack[model_depth-2];
      if (op == sme_pkg::OP_DIV && top == '0) r.status = sme_pkg::ST_DIVZ;
      else if (model_depth + grow > sme_pkg::STACK_DEPTH) r.status = sme_pkg::ST_OVER;
    end
    if (r.status == sme_pkg::ST_OK) begin
      case (op)
        sme_pkg::OP_PUSH: begin
          model_stack[model_depth] = lit;
          model_depth++;
        end
        sme_pkg::OP_ADD: begin
          model_stack[model_depth-2] = top + second;
          model_depth--;
        end
        sme_pkg::OP_SUB: begin
          model_stack[model_depth-2] = top - second;
          model_depth--;
        end
        sme_pkg::OP_DIV: begin
          model_stack[model_depth-2] = trunc_quotient(second, top);
          model_depth--;
        end
        sme_pkg::OP_MUL: begin
          model_stack[model_depth-2] = top * second;
          model_depth--;
        end
        sme_pkg::OP_PRINT: begin
          r.printed = 1'b1;
          r.value = top;
          model_depth--;
        end
        sme_pkg::OP_DUP: begin
          model_stack[model_depth] = top;
          model_depth++;
        end
        default: begin
          model_stack[model_depth] = second;
          model_stack[model_depth+1] = top;
          model_depth += 2;
        end
      endcase
    end
    r.depth = 7'(model_depth);
    status_seen[r.status]++;
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  // Literals: extremes, values near zero, and full-range noise
  function automatic logic [31:0] pick_literal();
    int v;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 0;
          default: v = -1;
        endcase
      end
      1, 2: begin
        v = $urandom_range(0, 40);
        v = v - 20;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("ERROR %s: got %0h, expected %0h", what, got, want);
  endtask

  // Send one operation beat; optional gap first, hold until accepted
  task automatic issue_op(sme_pkg::op_t op, logic [31:0] lit);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.op <= op;
    item_ch.literal <= lit;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
    ops_sent++;
    apply_stack_op(op, lit);
  endtask

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result, depth", 32'(result_ch.depth), '0);
      end else begin
        want = awaited_results.pop_front();
        if (want.printed) prints_seen++;
        if (result_ch.printed !== want.printed)
          report_mismatch("printed", 32'(result_ch.printed), 32'(want.printed));
        if (result_ch.print_value !== want.value)
          report_mismatch("print_value", result_ch.print_value, want.value);
        if (result_ch.status !== want.status)
          report_mismatch("status", 32'(result_ch.status), 32'(want.status));
        if (result_ch.depth !== want.depth)
          report_mismatch("depth", 32'(result_ch.depth), 32'(want.depth));
      end
    end
  end

  // Result-side backpressure in random bursts
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      result_ch.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      result_ch.ready <= 1'b0;
      ready_hold <= $urandom_range(0, 4);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d idle cycles", QUIET_LIMIT);
      $display("stack_machine_executor: mismatch");
      $finish;
    end
  end

  // Every op but push underflows on an empty stack
  task automatic test_empty_stack_underflow();
    issue_op(sme_pkg::OP_ADD, pick_literal());
    issue_op(sme_pkg::OP_SUB, pick_literal());
    issue_op(sme_pkg::OP_DIV, pick_literal());
    issue_op(sme_pkg::OP_MUL, pick_literal());
    issue_op(sme_pkg::OP_PRINT, pick_literal());
    issue_op(sme_pkg::OP_DUP, pick_literal());
    issue_op(sme_pkg::OP_DUP2, pick_literal());
  endtask

  // Wrapping add and multiply, quotient overflow, divide by zero, truncation
  task automatic test_arith_edges();
    issue_op(sme_pkg::OP_PUSH, 32'h7FFF_FFFF);
    issue_op(sme_pkg::OP_PUSH, 32'h0000_0001);
    issue_op(sme_pkg::OP_ADD, '0);              // wraps to min
    issue_op(sme_pkg::OP_PUSH, 32'hFFFF_FFFF);
    issue_op(sme_pkg::OP_DIV, '0);              // min / -1 stays min
    issue_op(sme_pkg::OP_DUP, '1);
    issue_op(sme_pkg::OP_MUL, '0);              // min * min wraps to zero
    issue_op(sme_pkg::OP_PUSH, '0);
    issue_op(sme_pkg::OP_DIV, '0);              // zero divisor, stack kept
    issue_op(sme_pkg::OP_PRINT, '0);
    issue_op(sme_pkg::OP_PUSH, 32'h8000_0000);
    issue_op(sme_pkg::OP_SUB, '0);              // top minus second
    issue_op(sme_pkg::OP_PUSH, 32'd3);
    issue_op(sme_pkg::OP_DIV, '0);              // rounds toward zero
    issue_op(sme_pkg::OP_DUP2, '0);             // one word only: underflow
    issue_op(sme_pkg::OP_PUSH, 32'hFFFF_FFF9);
    issue_op(sme_pkg::OP_DUP2, '0);
    issue_op(sme_pkg::OP_PRINT, '0);
  endtask

  // Mostly well-formed programs, with some ops that may underflow
  task automatic test_random_programs(int count);
    int            roll;
    sme_pkg::op_t  op;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) op = sme_pkg::op_t'($urandom_range(0, 7));
      else if (model_depth < 2)
        op = ($urandom_range(0, 2) == 0) ? sme_pkg::OP_DUP : sme_pkg::OP_PUSH;
      else if (model_depth > 40) op = sme_pkg::op_t'($urandom_range(1, 5));
      else op = sme_pkg::op_t'($urandom_range(0, 7));
      issue_op(op, pick_literal());
    end
  endtask

  // Grow to a full stack, hit overflow on every growing op, then drain
  task automatic test_fill_to_overflow();
    sme_pkg::op_t op;
    while (model_depth < sme_pkg::STACK_DEPTH) begin
      if (model_depth == 0) op = sme_pkg::OP_PUSH;
      else op = ($urandom_range(0, 2) == 0) ? sme_pkg::OP_PUSH :
                (($urandom_range(0, 1) == 0) ? sme_pkg::OP_DUP : sme_pkg::OP_DUP2);
      issue_op(op, pick_literal());
    end
    issue_op(sme_pkg::OP_PUSH, pick_literal());
    issue_op(sme_pkg::OP_DUP, pick_literal());
    issue_op(sme_pkg::OP_DUP2, pick_literal());
    issue_op(sme_pkg::OP_PRINT, pick_literal());
    issue_op(sme_pkg::OP_DUP2, pick_literal());   // one slot left: still overflow
    issue_op(sme_pkg::OP_DUP, pick_literal());
    while (model_depth > 0)
      issue_op(sme_pkg::op_t'($urandom_range(1, 5)), pick_literal());
  endtask

  initial begin
    item_ch.valid <= 1'b0;
    item_ch.op <= sme_pkg::OP_PUSH;
    item_ch.literal <= '0;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_empty_stack_underflow();
    test_arith_edges();
    test_random_programs(400);
    test_fill_to_overflow();
    idle_on = 1'b0;
    test_random_programs(200);

    // Drop valid, wait for the last results, then allow for stragglers
    item_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results never returned", 32'(awaited_results.size()), '0);

    $display("ran %0d ops, checked %0d results, %0d printed values", ops_sent,
             results_seen, prints_seen);
    $display("status mix: ok %0d, underflow %0d, overflow %0d, divide by zero %0d",
             status_seen[sme_pkg::ST_OK], status_seen[sme_pkg::ST_UNDER],
             status_seen[sme_pkg::ST_OVER], status_seen[sme_pkg::ST_DIVZ]);
    if (mismatches == 0) begin
      $display("stack_machine_executor: match");
    end else begin
      $display("stack_machine_executor: mismatch");
    end
    $finish;
  end

endmodule
